// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define MSL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define MSL_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/msl_pkg.sv =====
// Package of the servo slew limiter: sizes, codes, reset values, command/status structs.
// No dependencies; used by the interfaces, msl_ctrl, msl_dp, the top level and msl_chk.
`timescale 1ns / 1ps

package msl_pkg;

  // Sizing
  localparam int CHANNELS      = 16;
  localparam int FRACTION_BITS = 8;

  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int US_W    = 12;
  localparam int CH_W    = 4;
  localparam int MODE_W  = 3;
  localparam int SET_W   = 20;
  localparam int RATE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int INT_W   = 10;
  localparam int PULSE_W = US_W + FRACTION_BITS;         // fixed-point pulse / deadband
  localparam int PROD_W  = RATE_W + TIME_W;               // rate * elapsed ms, 8 frac bits
  localparam int STEP_W  = PROD_W + FRACTION_BITS - 8;    // product in pulse format
  localparam int SH_UP   = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
  localparam int SH_DN   = (FRACTION_BITS < 8) ? 8 - FRACTION_BITS : 0;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN       = 2'd2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TARGET     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TARGET_IMM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRESET     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RATE       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEADBAND   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd5;

  // Reset values and limits
  localparam logic [INT_W-1:0]   RST_INTERVAL = 10'd20;
  localparam logic [RATE_W-1:0]  RST_MIN_RATE = 16'd16;
  localparam logic [US_W-1:0]    RST_TARGET   = 12'd500;
  localparam logic [RATE_W-1:0]  RST_RATE     = 16'd256;
  localparam logic [RATE_W-1:0]  RATE_MAX     = 16'hFFFF;
  localparam logic [US_W-1:0]    US_MAX       = 12'd4095;
  localparam logic [PULSE_W-1:0] RST_CUR      = PULSE_W'(500) << FRACTION_BITS;
  localparam logic [PULSE_W-1:0] RST_DZ       = PULSE_W'(4) << FRACTION_BITS;
  localparam logic [PULSE_W-1:0] DZ_MIN       = PULSE_W'(1) << FRACTION_BITS;
  localparam logic [PULSE_W:0]   HALF         = (PULSE_W + 1)'(1) << (FRACTION_BITS - 1);

  // Controller -> datapath
  typedef struct packed {
    logic             wr_target;
    logic             wr_cur;
    logic             wr_rate;
    logic             wr_dz;
    logic             imm_emit;   // load pending word with immediate target
    logic             take_tick;  // store tick time and elapsed ms
    logic             issue;      // walk: look at channel idx
    logic             flush;      // move pending word out as final word
    logic [IDX_W-1:0] idx;
  } msl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic tick_ok;
    logic oe;
    logic hold;
    logic s1_valid;
    logic pend_valid;
    logic out_free;
  } msl_stat_t;

endpackage

// ===== rtl/msl_in_if.sv =====
// Input channel of the servo slew limiter: valid/ready plus one item.
// Depends on msl_pkg.
`timescale 1ns / 1ps

interface msl_in_if;
  logic                         valid;
  logic                         ready;
  logic [msl_pkg::MODE_W-1:0]   mode;
  logic [msl_pkg::CH_W-1:0]     channel;
  logic [msl_pkg::US_W-1:0]     pulse_us;
  logic [msl_pkg::SET_W-1:0]    setting;
  logic [msl_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, mode, channel, pulse_us, setting, now_ms, input ready);
  modport sink   (input valid, mode, channel, pulse_us, setting, now_ms, output ready);
endinterface

// ===== rtl/msl_out_if.sv =====
// Result channel of the servo slew limiter: valid/ready plus one pulse write.
// Depends on msl_pkg.
`timescale 1ns / 1ps

interface msl_out_if;
  logic                     valid;
  logic                     ready;
  logic [msl_pkg::CH_W-1:0] out_channel;
  logic [msl_pkg::US_W-1:0] out_pulse_us;
  logic                     last;

  modport source (output valid, out_channel, out_pulse_us, last, input ready);
  modport sink   (input valid, out_channel, out_pulse_us, last, output ready);
endinterface

// ===== rtl/multi_channel_servo_slew_limiter_top.sv =====
// Top level of the multi-channel servo slew limiter.
// Depends on msl_pkg, msl_in_if, msl_out_if, msl_ctrl and msl_dp.
`timescale 1ns / 1ps

// Sixteen-channel servo slew limiter. Each channel keeps a target pulse, a
// 12.8 fixed-point current pulse, an 8.8 us/ms step rate and a deadband.
// Input words set targets, preset positions, set rates and deadbands, or
// tick with the millisecond time; with the output enabled, an accepted tick
// moves every channel whose error exceeds its deadband toward its target by
// rate * elapsed ms, never past it, and emits one word per moved channel
// with last set on the final one. An immediate target with the output
// enabled emits a single word with last set. An acted-on tick takes the
// word, then walks the channel table entries through the two-stage step
// pipe, drains the pipe and issues the final word. The channel walk reads
// one table entry per cycle while the result side does not stall. The
// input is not ready while a tick walk or final word is in progress; a
// finished word waits in the output register while the next input word is
// taken. Configuration is written at any edge with cfg_we high; writes to
// an index past output_enable are dropped.
module multi_channel_servo_slew_limiter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  msl_in_if.sink                         in_if,
  msl_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [msl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [msl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  msl_pkg::msl_cmd_t  cmd;   // controller -> datapath
  msl_pkg::msl_stat_t stat;  // datapath -> controller

  // Sequencing: decode, tick walk, final-word flush.
  msl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Tables, step pipe, pending word and output register.
  msl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_channel  (in_if.channel),
    .in_pulse_us (in_if.pulse_us),
    .in_setting  (in_if.setting),
    .in_now_ms   (in_if.now_ms),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .out_if      (out_if)
  );

endmodule

// ===== rtl/msl_ctrl.sv =====
// Controller of the servo slew limiter: item decode, channel walk sequencing, final word.
// Depends on msl_pkg and msl_in_if.
`timescale 1ns / 1ps

module msl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  msl_in_if.sink             in_if,
  input  msl_pkg::msl_stat_t stat,
  output msl_pkg::msl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [msl_pkg::IDX_W-1:0] ctr_r, ctr_nxt;
  logic                      all_r, all_nxt;    // every channel issued
  logic                      acc;
  logic                      ch_ok;

  assign in_if.ready = rst_n && (state_r == ST_IDLE);
  assign acc         = in_if.valid && in_if.ready;
  assign ch_ok       = int'(in_if.channel) < msl_pkg::CHANNELS;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    all_nxt   = all_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.idx = msl_pkg::IDX_W'(in_if.channel);
        if (acc) begin
          unique case (in_if.mode)
            msl_pkg::MODE_TICK: begin
              if (stat.tick_ok) begin
                cmd.take_tick = 1'b1;
                if (stat.oe) begin
                  state_nxt = ST_WALK;
                  ctr_nxt   = '0;
                  all_nxt   = 1'b0;
                end
              end
            end
            msl_pkg::MODE_TARGET: begin
              cmd.wr_target = ch_ok;
            end
            msl_pkg::MODE_TARGET_IMM: begin
              if (ch_ok) begin
                cmd.wr_target = 1'b1;
                if (stat.oe) begin
                  cmd.wr_cur   = 1'b1;
                  cmd.imm_emit = 1'b1;
                  state_nxt    = ST_FLUSH;
                end
              end
            end
            msl_pkg::MODE_PRESET: begin
              cmd.wr_target = ch_ok;
              cmd.wr_cur    = ch_ok;
            end
            msl_pkg::MODE_RATE: begin
              cmd.wr_rate = ch_ok;
            end
            msl_pkg::MODE_DEADBAND: begin
              cmd.wr_dz = ch_ok;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.idx = ctr_r;
        if (!all_r && !stat.hold) begin
          cmd.issue = 1'b1;
          if (ctr_r == msl_pkg::IDX_W'(msl_pkg::CHANNELS - 1)) begin
            all_nxt = 1'b1;
          end else begin
            ctr_nxt = ctr_r + 1'b1;
          end
        end else if (all_r && !stat.s1_valid) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r   <= '0;
      all_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      all_r   <= all_nxt;
    end
  end

endmodule

// ===== rtl/msl_dp.sv =====
// Datapath of the servo slew limiter: channel tables, config registers, two-stage
// step pipe, pending word and output register. Depends on msl_pkg and msl_out_if.
`timescale 1ns / 1ps

module msl_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msl_pkg::msl_cmd_t             cmd,
  output msl_pkg::msl_stat_t            stat,
  input  logic [msl_pkg::CH_W-1:0]      in_channel,
  input  logic [msl_pkg::US_W-1:0]      in_pulse_us,
  input  logic [msl_pkg::SET_W-1:0]     in_setting,
  input  logic [msl_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                          cfg_we,
  input  logic [msl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [msl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  msl_out_if.source                     out_if
);

  // Config
  logic [msl_pkg::INT_W-1:0]  min_int_r;
  logic [msl_pkg::RATE_W-1:0] min_rate_r;
  logic                       oe_r;

  // Channel tables
  logic [msl_pkg::PULSE_W-1:0] cur_r  [msl_pkg::CHANNELS];
  logic [msl_pkg::US_W-1:0]    tgt_r  [msl_pkg::CHANNELS];
  logic [msl_pkg::RATE_W-1:0]  rate_r [msl_pkg::CHANNELS];
  logic [msl_pkg::PULSE_W-1:0] dz_r   [msl_pkg::CHANNELS];

  logic [msl_pkg::TIME_W-1:0] last_tick_r;
  logic [msl_pkg::TIME_W-1:0] dt_r;
  logic [msl_pkg::TIME_W-1:0] dt;

  // Stage 1 regs
  logic                        s1_valid_r;
  logic [msl_pkg::IDX_W-1:0]   s1_idx_r;
  logic                        s1_up_r;
  logic [msl_pkg::PULSE_W-1:0] s1_mag_r;
  logic [msl_pkg::PULSE_W-1:0] s1_cur_r;
  logic [msl_pkg::PROD_W-1:0]  s1_prod_r;

  // Pending and output words
  logic                     pend_valid_r, pend_valid_nxt;
  logic [msl_pkg::CH_W-1:0] pend_ch_r, pend_ch_nxt;
  logic [msl_pkg::US_W-1:0] pend_us_r, pend_us_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [msl_pkg::CH_W-1:0] out_ch_r, out_ch_nxt;
  logic [msl_pkg::US_W-1:0] out_us_r, out_us_nxt;
  logic                     out_last_r, out_last_nxt;

  // Stage 1 logic
  logic [msl_pkg::US_W-1:0]    tgt_rd;
  logic [msl_pkg::PULSE_W-1:0] cur_rd, dz_rd, tgt_fx, mag1;
  logic [msl_pkg::RATE_W-1:0]  rate_rd;
  logic                        up1, act1;
  logic [msl_pkg::PROD_W-1:0]  prod1;

  // Stage 2 logic
  logic [msl_pkg::STEP_W-1:0]  step2;
  logic [msl_pkg::PULSE_W-1:0] step_c, new2;
  logic [msl_pkg::PULSE_W:0]   rnd_sum, rnd_us;
  logic [msl_pkg::US_W-1:0]    us2;
  logic                        hold, go2, out_free;

  // Setting conversion
  logic [msl_pkg::RATE_W-1:0]  rate_set;
  logic [msl_pkg::PULSE_W-1:0] dz_set;

  assign dt       = in_now_ms - last_tick_r;
  assign out_free = !out_valid_r || out_if.ready;
  assign hold     = s1_valid_r && pend_valid_r && !out_free;
  assign go2      = s1_valid_r && !hold;

  assign stat.tick_ok    = dt >= msl_pkg::TIME_W'(min_int_r);
  assign stat.oe         = oe_r;
  assign stat.hold       = hold;
  assign stat.s1_valid   = s1_valid_r;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  assign out_if.valid        = out_valid_r;
  assign out_if.out_channel  = out_ch_r;
  assign out_if.out_pulse_us = out_us_r;
  assign out_if.last         = out_last_r;

  // Rate floor and ceiling, deadband floor
  always_comb begin
    if (in_setting < msl_pkg::SET_W'(min_rate_r)) begin
      rate_set = min_rate_r;
    end else if (in_setting > msl_pkg::SET_W'(msl_pkg::RATE_MAX)) begin
      rate_set = msl_pkg::RATE_MAX;
    end else begin
      rate_set = in_setting[msl_pkg::RATE_W-1:0];
    end
    if (msl_pkg::FRACTION_BITS >= 8) begin
      dz_set = msl_pkg::PULSE_W'(in_setting) << msl_pkg::SH_UP;
    end else begin
      dz_set = msl_pkg::PULSE_W'(in_setting >> msl_pkg::SH_DN);
    end
    if (dz_set < msl_pkg::DZ_MIN) begin
      dz_set = msl_pkg::DZ_MIN;
    end
  end

  // Stage 1: error, direction, deadband test, rate * dt
  always_comb begin
    tgt_rd  = tgt_r[cmd.idx];
    cur_rd  = cur_r[cmd.idx];
    rate_rd = rate_r[cmd.idx];
    dz_rd   = dz_r[cmd.idx];
    tgt_fx  = msl_pkg::PULSE_W'(tgt_rd) << msl_pkg::FRACTION_BITS;
    up1     = tgt_fx > cur_rd;
    mag1    = up1 ? (tgt_fx - cur_rd) : (cur_rd - tgt_fx);
    act1    = mag1 > dz_rd;
    prod1   = msl_pkg::PROD_W'(rate_rd) * msl_pkg::PROD_W'(dt_r);
  end

  // Stage 2: clamp step, move, round half up, clip at US_MAX
  always_comb begin
    if (msl_pkg::FRACTION_BITS >= 8) begin
      step2 = msl_pkg::STEP_W'(s1_prod_r) << msl_pkg::SH_UP;
    end else begin
      step2 = msl_pkg::STEP_W'(s1_prod_r >> msl_pkg::SH_DN);
    end
    step_c  = (step2 > msl_pkg::STEP_W'(s1_mag_r)) ? s1_mag_r
                                                   : step2[msl_pkg::PULSE_W-1:0];
    new2    = s1_up_r ? (s1_cur_r + step_c) : (s1_cur_r - step_c);
    rnd_sum = {1'b0, new2} + msl_pkg::HALF;
    rnd_us  = rnd_sum >> msl_pkg::FRACTION_BITS;
    us2     = (rnd_us > (msl_pkg::PULSE_W + 1)'(msl_pkg::US_MAX)) ? msl_pkg::US_MAX
                                                                 : rnd_us[msl_pkg::US_W-1:0];
  end

  // Pending word holds the newest write until we know whether it is the final one.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_ch_nxt    = pend_ch_r;
    pend_us_nxt    = pend_us_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_ch_nxt     = out_ch_r;
    out_us_nxt     = out_us_r;
    out_last_nxt   = out_last_r;
    if (go2) begin
      pend_valid_nxt = 1'b1;
      pend_ch_nxt    = msl_pkg::CH_W'(s1_idx_r);
      pend_us_nxt    = us2;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_ch_nxt    = pend_ch_r;
        out_us_nxt    = pend_us_r;
        out_last_nxt  = 1'b0;
      end
    end else if (cmd.imm_emit) begin
      pend_valid_nxt = 1'b1;
      pend_ch_nxt    = in_channel;
      pend_us_nxt    = in_pulse_us;
    end else if (cmd.flush) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_ch_nxt     = pend_ch_r;
      out_us_nxt     = pend_us_r;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r    <= msl_pkg::RST_INTERVAL;
      min_rate_r   <= msl_pkg::RST_MIN_RATE;
      oe_r         <= 1'b1;
      last_tick_r  <= '0;
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < msl_pkg::CHANNELS; i++) begin
        cur_r[i]  <= msl_pkg::RST_CUR;
        tgt_r[i]  <= msl_pkg::RST_TARGET;
        rate_r[i] <= msl_pkg::RST_RATE;
        dz_r[i]   <= msl_pkg::RST_DZ;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          msl_pkg::CFG_MIN_INTERVAL: min_int_r  <= cfg_wdata[msl_pkg::INT_W-1:0];
          msl_pkg::CFG_MIN_RATE:     min_rate_r <= cfg_wdata[msl_pkg::RATE_W-1:0];
          msl_pkg::CFG_OUT_EN:       oe_r       <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (cmd.take_tick) begin
        last_tick_r <= in_now_ms;
      end
      if (!hold) begin
        s1_valid_r <= cmd.issue && act1;
      end
      if (go2) begin
        cur_r[s1_idx_r] <= new2;
      end else if (cmd.wr_cur) begin
        cur_r[cmd.idx] <= msl_pkg::PULSE_W'(in_pulse_us) << msl_pkg::FRACTION_BITS;
      end
      if (cmd.wr_target) begin
        tgt_r[cmd.idx] <= in_pulse_us;
      end
      if (cmd.wr_rate) begin
        rate_r[cmd.idx] <= rate_set;
      end
      if (cmd.wr_dz) begin
        dz_r[cmd.idx] <= dz_set;
      end
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.take_tick) begin
      dt_r <= dt;
    end
    if (!hold) begin
      s1_idx_r  <= cmd.idx;
      s1_up_r   <= up1;
      s1_mag_r  <= mag1;
      s1_cur_r  <= cur_rd;
      s1_prod_r <= prod1;
    end
    pend_ch_r  <= pend_ch_nxt;
    pend_us_r  <= pend_us_nxt;
    out_ch_r   <= out_ch_nxt;
    out_us_r   <= out_us_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== rtl/msl_chk.sv =====
// Port-level checker for the servo slew limiter, bound to the top level.
// Depends on msl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msl_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [msl_pkg::MODE_W-1:0]   in_mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [msl_pkg::CH_W-1:0]     out_channel,
  input logic [msl_pkg::US_W-1:0]     out_pulse_us,
  input logic                         out_last
);

  // Result word held while stalled
  `MSL_ASSERT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready |=> out_valid, "out valid dropped while stalled")
  `MSL_ASSERT(a_out_word_holds, clk, rst_n, out_valid && !out_ready |=> $stable(out_channel) && $stable(out_pulse_us) && $stable(out_last), "out word changed while stalled")
  // Words that emit nothing leave the input ready
  `MSL_ASSERT(a_plain_mode_ready, clk, rst_n, in_valid && in_ready && (in_mode == msl_pkg::MODE_TARGET || in_mode == msl_pkg::MODE_PRESET || in_mode == msl_pkg::MODE_RATE || in_mode == msl_pkg::MODE_DEADBAND) |=> in_ready, "input not ready after a setting word")
  // Reset empties the output register
  `MSL_ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid, "out valid after reset")

endmodule

bind multi_channel_servo_slew_limiter_top msl_chk u_msl_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_mode      (in_if.mode),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_channel  (out_if.out_channel),
  .out_pulse_us (out_if.out_pulse_us),
  .out_last     (out_if.last)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the multi-channel servo slew limiter top level.
// Depends on msl_pkg, msl_in_if, msl_out_if and multi_channel_servo_slew_limiter_top.
`timescale 1ns / 1ps

module tb_top;
  import msl_pkg::*;

  // Modes the block must drop without a word
  localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;

  localparam int SETTLE_CYCLES = 40;    // longer than a tick walk, with margin
  localparam int HOLD_CYCLES   = 400;   // long result-side hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int IDLE_PCT      = 19;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [US_W-1:0] us;
    logic            last;
  } pulse_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  msl_in_if  in_bus ();
  msl_out_if out_bus ();

  multi_channel_servo_slew_limiter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predicted block state: per-channel slew tables plus register copies.
  // ---------------------------------------------------------------------
  logic [PULSE_W-1:0] pos_q   [CHANNELS];   // fixed-point current pulse
  logic [US_W-1:0]    aim_us  [CHANNELS];   // target pulse, whole us
  logic [RATE_W-1:0]  slew    [CHANNELS];   // 8.8 us per ms
  logic [PULSE_W-1:0] band    [CHANNELS];   // deadband, fixed point
  logic [TIME_W-1:0]  prev_tick_ms;
  logic [INT_W-1:0]   iv_ms;
  logic [RATE_W-1:0]  rate_floor;
  logic               drive_on;

  pulse_word_t pending_words[$];   // words the block still owes us

  int  n_errors  = 0;
  int  n_reports = 0;
  bit  quiet     = 1'b0;   // no idling on either side while set
  bit  hold_req  = 1'b0;
  int  hold_left = 0;

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Round half up to whole us, clip at the 12-bit ceiling.
  function automatic pulse_word_t word_of(int ch, logic [PULSE_W-1:0] pos);
    pulse_word_t w;
    logic [PULSE_W:0] us;
    us = ({1'b0, pos} + HALF) >> FRACTION_BITS;
    w.ch = ch[CH_W-1:0];
    w.us = (us > (PULSE_W + 1)'(US_MAX)) ? US_MAX : us[US_W-1:0];
    w.last = 1'b0;
    return w;
  endfunction

  task automatic reset_servo_model();
    iv_ms        = RST_INTERVAL;
    rate_floor   = RST_MIN_RATE;
    drive_on     = 1'b1;
    prev_tick_ms = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      pos_q[i]  = RST_CUR;
      aim_us[i] = RST_TARGET;
      slew[i]   = RST_RATE;
      band[i]   = RST_DZ;
    end
  endtask

  // Applies one accepted word to the model and queues the words it causes.
  task automatic predict_servo_words(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                                     logic [US_W-1:0] pulse, logic [SET_W-1:0] setting,
                                     logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] dt;
    logic [63:0] goal, cur, mag, step, val;
    bit up;
    int n;
    n = 0;
    case (mode)
      MODE_TICK: begin
        dt = now - prev_tick_ms;
        if (dt >= TIME_W'(iv_ms)) begin
          prev_tick_ms = now;
          if (drive_on) begin
            for (int i = 0; i < CHANNELS; i++) begin
              goal = 64'(aim_us[i]) << FRACTION_BITS;
              cur  = 64'(pos_q[i]);
              up   = goal > cur;
              mag  = up ? goal - cur : cur - goal;
              if (mag > 64'(band[i])) begin
                step = ((64'(slew[i]) * 64'(dt)) << SH_UP) >> SH_DN;
                if (step > mag) step = mag;   // never overshoot
                cur = up ? cur + step : cur - step;
                pos_q[i] = cur[PULSE_W-1:0];
                pending_words.push_back(word_of(i, pos_q[i]));
                n++;
              end
            end
            if (n > 0) pending_words[pending_words.size()-1].last = 1'b1;
          end
        end
      end
      MODE_TARGET: aim_us[ch] = pulse;
      MODE_TARGET_IMM: begin
        aim_us[ch] = pulse;
        if (drive_on) begin
          pos_q[ch] = PULSE_W'(pulse) << FRACTION_BITS;
          pending_words.push_back(word_of(ch, pos_q[ch]));
          pending_words[pending_words.size()-1].last = 1'b1;
        end
      end
      MODE_PRESET: begin
        aim_us[ch] = pulse;
        pos_q[ch]  = PULSE_W'(pulse) << FRACTION_BITS;
      end
      MODE_RATE: begin
        val = 64'(setting);
        if (val < 64'(rate_floor)) val = 64'(rate_floor);
        if (val > 64'(RATE_MAX)) val = 64'(RATE_MAX);
        slew[ch] = val[RATE_W-1:0];
      end
      MODE_DEADBAND: begin
        val = (64'(setting) << SH_UP) >> SH_DN;
        if (val < 64'(DZ_MIN)) val = 64'(DZ_MIN);
        band[ch] = val[PULSE_W-1:0];
      end
      default: ;   // reserved modes change nothing
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Offer one word, with random idle cycles first; valid stays high into
  // the next call unless that call idles.
  task automatic send_word(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                           logic [US_W-1:0] pulse, logic [SET_W-1:0] setting,
                           logic [TIME_W-1:0] now);
    @(negedge clk);
    while (idle_roll()) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.mode     <= mode;
    in_bus.channel  <= ch;
    in_bus.pulse_us <= pulse;
    in_bus.setting  <= setting;
    in_bus.now_ms   <= now;
    do @(posedge clk); while (!in_bus.ready);
    predict_servo_words(mode, ch, pulse, setting, now);
  endtask

  task automatic tick_at(logic [TIME_W-1:0] now);
    send_word(MODE_TICK, CH_W'($urandom), US_W'($urandom), SET_W'($urandom), now);
  endtask

  // Drop valid, wait out every owed word, then let any silent walk finish.
  task automatic wait_drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic cfg_set(logic [INT_W-1:0] interval, logic [RATE_W-1:0] floor_rate,
                         logic oe);
    wait_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MIN_INTERVAL;
    cfg_wdata <= CFG_DATA_W'(interval);
    @(posedge clk);
    iv_ms = interval;
    @(negedge clk);
    cfg_idx   <= CFG_MIN_RATE;
    cfg_wdata <= floor_rate;
    @(posedge clk);
    rate_floor = floor_rate;
    @(negedge clk);
    cfg_idx   <= CFG_OUT_EN;
    cfg_wdata <= CFG_DATA_W'(oe);
    @(posedge clk);
    drive_on = oe;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus a long counted hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !idle_roll();
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted word against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_words.size() == 0) begin
        n_errors++;
        if (n_reports < MAX_REPORTS) begin
          n_reports++;
          $display("unexpected word: ch=%0d us=%0d last=%0b", out_bus.out_channel,
                   out_bus.out_pulse_us, out_bus.last);
        end
      end else begin
        want = pending_words.pop_front();
        if (out_bus.out_channel !== want.ch || out_bus.out_pulse_us !== want.us ||
            out_bus.last !== want.last) begin
          n_errors++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("word mismatch: exp ch=%0d us=%0d last=%0b, got ch=%0d us=%0d last=%0b",
                     want.ch, want.us, want.last, out_bus.out_channel,
                     out_bus.out_pulse_us, out_bus.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run once no handshake has happened for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stuck = 0;
      else stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Field extremes, every mode, rate and deadband floors, early and
  // wrapping ticks, all under reset register values.
  task automatic test_directed();
    tick_at(32'd10);                                          // early: dt below interval
    send_word(MODE_RSVD_A, 4'd0, 12'd0, 20'd0, 32'd0);        // reserved mode
    send_word(MODE_RSVD_B, 4'hF, 12'hFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    send_word(MODE_TARGET, 4'd0, 12'd0, 20'd0, 32'd0);
    send_word(MODE_TARGET, 4'd15, US_MAX, 20'hFFFFF, 32'hFFFF_FFFF);
    send_word(MODE_TARGET_IMM, 4'd3, US_MAX, 20'd0, 32'd0);
    send_word(MODE_TARGET_IMM, 4'd4, 12'd0, 20'd0, 32'd0);
    send_word(MODE_PRESET, 4'd5, 12'd2048, 20'd0, 32'd0);
    send_word(MODE_RATE, 4'd0, 12'd0, 20'd0, 32'd0);          // raised to the floor
    send_word(MODE_RATE, 4'd15, 12'd0, 20'hFFFFF, 32'd0);     // saturates
    send_word(MODE_RATE, 4'd1, 12'd0, 20'd300, 32'd0);
    send_word(MODE_DEADBAND, 4'd2, 12'd0, 20'd0, 32'd0);      // raised to 1 us
    send_word(MODE_DEADBAND, 4'd3, 12'd0, 20'hFFFFF, 32'd0);  // freezes channel 3
    send_word(MODE_TARGET, 4'd1, 12'd600, 20'd0, 32'd0);
    send_word(MODE_DEADBAND, 4'd1, 12'd0, 20'h00280, 32'd0);
    send_word(MODE_TARGET, 4'd2, 12'd501, 20'd0, 32'd0);      // error equals deadband
    send_word(MODE_TARGET, 4'd6, 12'd505, 20'd0, 32'd0);
    tick_at(32'd25);
    tick_at(32'd45);
    tick_at(32'hFFFF_FFF0);                                   // huge dt: all settle
    send_word(MODE_TARGET, 4'd7, 12'd510, 20'd0, 32'd0);
    tick_at(32'h0000_0010);                                   // time wraps
    tick_at(32'h0000_0020);                                   // early by 4 ms
  endtask

  // With the driver detached: immediate target only stores, tick only
  // records its time.
  task automatic test_output_disable();
    cfg_set(RST_INTERVAL, RST_MIN_RATE, 1'b0);
    send_word(MODE_TARGET_IMM, 4'd8, 12'd1000, 20'd0, 32'd0);
    tick_at(prev_tick_ms + 32'd25);
    send_word(MODE_TARGET, 4'd9, 12'd100, 20'd0, 32'd0);
    tick_at(prev_tick_ms + 32'd30);
    cfg_set(RST_INTERVAL, RST_MIN_RATE, 1'b1);
    tick_at(prev_tick_ms + 32'd30);
  endtask

  // Register extremes: zero interval with zero floor (frozen channel), then
  // an interval of 1000 ms with the highest floor.
  task automatic test_config_extremes();
    cfg_set('0, '0, 1'b1);
    send_word(MODE_RATE, 4'd10, 12'd0, 20'd0, 32'd0);
    send_word(MODE_TARGET, 4'd10, 12'd3000, 20'd0, 32'd0);
    tick_at(prev_tick_ms);                                    // dt of zero accepted
    tick_at(prev_tick_ms + 32'd5);
    cfg_set(10'd1000, RATE_MAX, 1'b1);
    send_word(MODE_RATE, 4'd10, 12'd0, 20'd5, 32'd0);
    tick_at(prev_tick_ms + 32'd999);
    tick_at(prev_tick_ms + 32'd1000);
    cfg_set(10'd1, 16'd1, 1'b1);
    send_word(MODE_RATE, 4'd11, 12'd0, 20'd0, 32'd0);
    send_word(MODE_TARGET, 4'd11, 12'd700, 20'd0, 32'd0);
    tick_at(prev_tick_ms + 32'd1);
  endtask

  // Far targets on half the channels, then ticks while the result side is
  // held off, so the walk stalls and the input backs up.
  task automatic test_backpressure();
    cfg_set(RST_INTERVAL, RST_MIN_RATE, 1'b1);
    for (int c = 0; c < CHANNELS; c += 2) begin
      send_word(MODE_PRESET, CH_W'(c), 12'd0, 20'd0, 32'd0);
      send_word(MODE_TARGET, CH_W'(c), US_MAX, 20'd0, 32'd0);
    end
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++) tick_at(prev_tick_ms + 32'd20);
  endtask

  // One random word, weighted toward well-formed traffic: targets, rates
  // and timely ticks, with early ticks, time jumps and reserved modes.
  task automatic rand_item();
    int r, t;
    logic [TIME_W-1:0] now;
    logic [SET_W-1:0] set_v;
    r = $urandom_range(99);
    if (r < 25) begin
      send_word(MODE_TARGET, CH_W'($urandom), US_W'($urandom), SET_W'($urandom), $urandom);
    end else if (r < 30) begin
      send_word(MODE_TARGET_IMM, CH_W'($urandom), US_W'($urandom), SET_W'($urandom),
                $urandom);
    end else if (r < 35) begin
      send_word(MODE_PRESET, CH_W'($urandom), US_W'($urandom), SET_W'($urandom), $urandom);
    end else if (r < 45) begin
      set_v = ($urandom_range(3) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(4000));
      send_word(MODE_RATE, CH_W'($urandom), US_W'($urandom), set_v, $urandom);
    end else if (r < 52) begin
      set_v = ($urandom_range(4) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(2560));
      send_word(MODE_DEADBAND, CH_W'($urandom), US_W'($urandom), set_v, $urandom);
    end else if (r < 95) begin
      t = $urandom_range(99);
      if (t < 10 && iv_ms != 0) now = prev_tick_ms + TIME_W'($urandom_range(iv_ms - 1));
      else if (t < 15) now = $urandom;
      else now = prev_tick_ms + TIME_W'(iv_ms) + TIME_W'($urandom_range(40));
      tick_at(now);
    end else begin
      send_word((r < 98) ? MODE_RSVD_A : MODE_RSVD_B, CH_W'($urandom), US_W'($urandom),
                SET_W'($urandom), $urandom);
    end
  endtask

  // Five phases of random traffic, each under its own register setting;
  // the second runs with no idling on either side.
  task automatic test_random();
    cfg_set(RST_INTERVAL, RST_MIN_RATE, 1'b1);
    repeat (35) rand_item();
    cfg_set(10'd0, 16'd0, 1'b1);
    quiet = 1'b1;
    repeat (35) rand_item();
    wait_drain();
    quiet = 1'b0;
    cfg_set(10'd1000, RATE_MAX, 1'b1);
    repeat (35) rand_item();
    cfg_set(10'd30, 16'd200, 1'b0);
    repeat (35) rand_item();
    cfg_set(10'd5, 16'd1, 1'b1);
    repeat (35) rand_item();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.mode     = '0;
    in_bus.channel  = '0;
    in_bus.pulse_us = '0;
    in_bus.setting  = '0;
    in_bus.now_ms   = '0;
    out_bus.ready   = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    reset_servo_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_output_disable();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_drain();

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== multi_channel_servo_slew_limiter_top.f =====
+incdir+rtl
rtl/msl_pkg.sv
rtl/msl_in_if.sv
rtl/msl_out_if.sv
rtl/msl_ctrl.sv
rtl/msl_dp.sv
rtl/multi_channel_servo_slew_limiter_top.sv
rtl/msl_chk.sv
bench/tb_top.sv
